// ----- rtl/wsd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_end;
    } wsd_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [3:0] frame_opcode;
        logic       frame_end;
        logic [1:0] status;
    } wsd_out_t;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_HDR_TRUNC    = 2'd1;
    localparam logic [1:0] ST_PAYLOAD_TRUNC = 2'd2;
    localparam logic [1:0] ST_OVER_LIMIT   = 2'd3;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;
    localparam logic [3:0] KEY_BYTES    = 4'd4;

    localparam logic [31:0] MAX_LEN_RESET = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// ----- rtl/wsd_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wsd_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire wsd_pkg::wsd_in_t item,
    input  wire logic [31:0]      max_len,
    output logic                  res_valid,
    output wsd_pkg::wsd_out_t     res
);

    typedef enum logic [4:0] {
        PH_START = 5'b00001,
        PH_LEN   = 5'b00010,
        PH_EXT   = 5'b00100,
        PH_KEY   = 5'b01000,
        PH_DATA  = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_reg, mask_next;
    logic [6:0]  code_reg, code_next;
    logic [3:0]  cnt_reg, cnt_next;
    // holds the payload length, then counts down the bytes still due
    logic [63:0] len_reg, len_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  idx_reg, idx_next;

    logic        emit;
    logic        hdr_done;
    logic        enter;
    logic [63:0] ext_len;
    logic [3:0]  cnt_inc;
    logic [3:0]  need;
    logic [7:0]  key_byte;
    logic        last;
    logic [7:0]  b;

    assign b       = item.in_byte;
    assign last    = item.in_end;
    assign ext_len = {len_reg[55:0], b};
    assign cnt_inc = cnt_reg + 4'd1;
    assign need    = (code_reg == wsd_pkg::LEN_CODE_64) ? wsd_pkg::EXT_BYTES_64
                                                        : wsd_pkg::EXT_BYTES_16;

    always_comb
    begin
        case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        code_next   = code_reg;
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        emit        = 1'b0;
        hdr_done    = 1'b0;
        enter       = 1'b0;
        res         = '0;

        unique case (phase_reg)
            PH_LEN:
            begin
                mask_next = b[7];
                code_next = b[6:0];
                cnt_next  = 4'd0;
                if (b[6:0] == wsd_pkg::LEN_CODE_16 || b[6:0] == wsd_pkg::LEN_CODE_64)
                begin
                    len_next   = '0;
                    phase_next = PH_EXT;
                    if (last)
                    begin
                        emit       = 1'b1;
                        res.status = wsd_pkg::ST_HDR_TRUNC;
                    end
                end
                else
                begin
                    len_next = {57'd0, b[6:0]};
                    hdr_done = 1'b1;
                end
            end

            PH_EXT:
            begin
                len_next = ext_len;
                cnt_next = cnt_inc;
                if (cnt_inc < need)
                begin
                    if (last)
                    begin
                        emit       = 1'b1;
                        res.status = wsd_pkg::ST_HDR_TRUNC;
                    end
                end
                else if (code_reg == wsd_pkg::LEN_CODE_64
                         && (|ext_len[63:32] || ext_len[31:0] > max_len))
                begin
                    emit       = 1'b1;
                    res.status = wsd_pkg::ST_OVER_LIMIT;
                end
                else
                begin
                    hdr_done = 1'b1;
                end
            end

            PH_KEY:
            begin
                key_next = {key_reg[23:0], b};
                cnt_next = cnt_inc;
                if (cnt_inc < wsd_pkg::KEY_BYTES)
                begin
                    if (last)
                    begin
                        emit       = 1'b1;
                        res.status = wsd_pkg::ST_HDR_TRUNC;
                    end
                end
                else
                begin
                    enter = 1'b1;
                end
            end

            PH_DATA:
            begin
                emit           = 1'b1;
                res.byte_valid = 1'b1;
                res.out_byte   = mask_reg ? (b ^ key_byte) : b;
                idx_next       = idx_reg + 2'd1;
                len_next       = len_reg - 64'd1;
                if (len_reg == 64'd1)
                begin
                    res.frame_end = 1'b1;
                end
                else if (last)
                begin
                    res.frame_end = 1'b1;
                    res.status    = wsd_pkg::ST_PAYLOAD_TRUNC;
                end
            end

            default:
            begin
                opcode_next = b[3:0];
                phase_next  = PH_LEN;
                if (last)
                begin
                    emit       = 1'b1;
                    res.status = wsd_pkg::ST_HDR_TRUNC;
                end
            end
        endcase

        if (hdr_done)
        begin
            cnt_next = 4'd0;
            if (mask_next)
            begin
                phase_next = PH_KEY;
                if (last)
                begin
                    emit       = 1'b1;
                    res.status = wsd_pkg::ST_HDR_TRUNC;
                end
            end
            else
            begin
                enter = 1'b1;
            end
        end

        if (enter)
        begin
            if (len_next == 64'd0)
            begin
                emit       = 1'b1;
                res.status = wsd_pkg::ST_OK;
            end
            else
            begin
                phase_next = PH_DATA;
                idx_next   = 2'd0;
                if (last)
                begin
                    emit       = 1'b1;
                    res.status = wsd_pkg::ST_PAYLOAD_TRUNC;
                end
            end
        end

        // every result outside the payload closes the frame
        if (phase_reg != PH_DATA)
        begin
            res.frame_end = emit;
        end
        if (emit && res.frame_end)
        begin
            phase_next = PH_START;
        end
        res.frame_opcode = opcode_next;
    end

    assign res_valid = accept & emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            opcode_reg <= '0;
            mask_reg   <= 1'b0;
            code_reg   <= '0;
            cnt_reg    <= '0;
            len_reg    <= '0;
            key_reg    <= '0;
            idx_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            code_reg   <= code_next;
            cnt_reg    <= cnt_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            idx_reg    <= idx_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/wsd_out_buf.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wsd_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire wsd_pkg::wsd_out_t push_item,
    output logic                   space,
    output logic                   tx_valid,
    input  wire logic              tx_ready,
    output wsd_pkg::wsd_out_t      tx_item
);

    logic              main_valid_reg;
    wsd_pkg::wsd_out_t main_reg;
    logic              skid_valid_reg;
    wsd_pkg::wsd_out_t skid_reg;

    // push never coincides with a full skid slot
    assign space    = !skid_valid_reg;
    assign tx_valid = main_valid_reg;
    assign tx_item  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || tx_ready)
        begin
            main_valid_reg <= skid_valid_reg | push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || tx_ready)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_item;
        end
        else if (push)
        begin
            skid_reg <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/websocket_frame_deframer_top.sv -----
// Channel   Handshake            Payload
// rx        rx_valid / rx_ready  rx_item   (wsd_in_t: in_byte, in_end)
// tx        tx_valid / tx_ready  tx_item   (wsd_out_t: out_byte, byte_valid, ...)
// cfg       cfg_we               cfg_wdata (max_payload_len)
//
// One byte per cycle while rx_ready is high; the result of a byte is registered in
// the output buffer before it appears on tx. The parse state updates in the same
// cycle as the transaction. rx_ready comes from a register: it drops only while the
// two-entry output buffer is full, so a stall on tx reaches rx once its skid entry fills.
// rst_n is asynchronous; after reset the parser expects the first header byte.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rx_valid,
    output logic                   rx_ready,
    input  wire wsd_pkg::wsd_in_t  rx_item,
    output logic                   tx_valid,
    input  wire logic              tx_ready,
    output wsd_pkg::wsd_out_t      tx_item,
    input  wire logic              cfg_we,
    input  wire logic [31:0]       cfg_wdata
);

    logic [31:0]       max_len_q_reg;
    logic              accept;
    logic              res_valid;
    wsd_pkg::wsd_out_t res;

    assign accept = rx_valid & rx_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_q_reg <= wsd_pkg::MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            max_len_q_reg <= cfg_wdata;
        end
    end

    wsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (rx_item),
        .max_len   (max_len_q_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    wsd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_item (res),
        .space     (rx_ready),
        .tx_valid  (tx_valid),
        .tx_ready  (tx_ready),
        .tx_item   (tx_item)
    );

endmodule

`default_nettype wire
